// ===== src/rpp_pkg.sv =====
// Shared types and constants for the RAMDAC palette and PLL write port.
package rpp_pkg;

    localparam int REF_W      = 26;
    localparam int CLK_W      = 33;
    localparam int DIVISOR_W  = 8;
    localparam int STEP_W     = 6;
    localparam logic [STEP_W-1:0] DIV_STEPS = 6'd33;

    localparam logic [REF_W-1:0] REF_CLK_RESET = 26'd14318180;

    // Direct register codes
    localparam logic [2:0] ACT_PAL_ADDR  = 3'd0;
    localparam logic [2:0] ACT_PAL_DATA  = 3'd1;
    localparam logic [2:0] ACT_PIX_MASK  = 3'd2;
    localparam logic [2:0] ACT_IDX_LOW   = 3'd3;
    localparam logic [2:0] ACT_IDX_HIGH  = 3'd4;
    localparam logic [2:0] ACT_IDX_DATA  = 3'd5;

    // Indexed register addresses
    localparam logic [7:0] IDX_CLK_CNTL   = 8'h02;
    localparam logic [7:0] IDX_PIX_FORMAT = 8'h0A;
    localparam logic [7:0] IDX_PLL_CTL    = 8'h10;
    localparam logic [7:0] IDX_FREQ_M     = 8'h20;
    localparam logic [7:0] IDX_FREQ_N     = 8'h21;

    localparam logic [1:0] PLL_SRC_OK   = 2'd1;
    localparam logic [7:0] PIX_FMT_8BPP = 8'd3;
    localparam logic [7:0] VCO_OFFSET   = 8'd65;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_UNIMPL    = 3'd1,
        ERR_PLL_SRC   = 3'd2,
        ERR_PIX_FMT   = 3'd3,
        ERR_ZERO_DIV  = 3'd4
    } err_code_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV
    } state_t;

    typedef struct packed {
        logic             palette_write;
        logic [7:0]       palette_index;
        logic [7:0]       palette_red;
        logic [7:0]       palette_green;
        logic [7:0]       palette_blue;
        logic             clock_update;
        logic [CLK_W-1:0] pixel_clock_hz;
        logic             depth_set;
        err_code_t        error_code;
    } result_t;

    typedef struct packed {
        logic                 start;
        logic [CLK_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [CLK_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== src/rpp_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module rpp_divider
    import rpp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [CLK_W-1:0]     q_reg, q_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [STEP_W-1:0]    cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIVISOR_W:0]   trial;

    assign trial = {rem_reg, q_reg[CLK_W-1]};

    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            q_next    = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = DIVISOR_W'(trial - {1'b0, dvs_reg});
                q_next   = {q_reg[CLK_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIVISOR_W-1:0];
                q_next   = {q_reg[CLK_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == DIV_STEPS - STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

// ===== src/ramdac_palette_and_pll_port_unit.sv =====
// RAMDAC write port: palette loader, indexed registers and dot clock PLL calculator.
//
// Usage: each s_ beat is one host byte write (s_action selects the direct
// register, s_data_byte is the byte). Every beat yields exactly one m_ beat.
// cfg_wr_en/cfg_wr_data load the PLL reference frequency (Hz); write it only
// while no beat is in flight.
// Result path: every write except a clock control write that starts the PLL
// calculation lands its result in the holding register and then in the output
// register, where m_valid rises. A PLL write runs through the multiply state,
// the 33-step serial divider that produces one quotient bit per cycle, the
// divider done flag, the holding register and the output register. The
// block takes no new beat while the divider runs or the holding register is
// full, so it takes no new write until the result of the last one has left
// the holding register.
// A finished result sits in a one-entry holding register ahead of the output
// register, so one more input beat is taken while the receiver stalls; after
// that s_ready drops until m_ready lets the output drain.
// Reset (aresetn low, synchronous) clears the palette pointer, component
// count, held colors, index and PLL registers and empties both result
// registers; the reference frequency returns to 14318180 Hz.
module ramdac_palette_and_pll_port_unit
    import rpp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [REF_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [2:0]       s_action,
    input  logic [7:0]       s_data_byte,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_palette_write,
    output logic [7:0]       m_palette_index,
    output logic [7:0]       m_palette_red,
    output logic [7:0]       m_palette_green,
    output logic [7:0]       m_palette_blue,
    output logic             m_clock_update,
    output logic [CLK_W-1:0] m_pixel_clock_hz,
    output logic             m_depth_set,
    output logic [2:0]       m_error_code
);

    state_t state_reg, state_next;

    logic [REF_W-1:0] ref_clk_reg;
    logic [7:0] pal_ptr_reg, pal_ptr_next;
    logic [1:0] comp_cnt_reg, comp_cnt_next;
    logic [7:0] red_reg, red_next;
    logic [7:0] green_reg, green_next;
    logic [7:0] idx_low_reg, idx_low_next;
    logic [7:0] idx_high_reg, idx_high_next;
    logic [7:0] pll_ctl_reg, pll_ctl_next;
    logic [7:0] freq_m_reg, freq_m_next;
    logic [7:0] freq_n_reg, freq_n_next;

    result_t pend_res_reg, pend_res_next;
    logic    pend_vld_reg, pend_vld_next;
    result_t out_res_reg;
    logic    out_vld_reg;

    logic accept;
    logic out_free;

    logic [7:0]           vco;
    logic [DIVISOR_W-1:0] divisor;
    logic [REF_W+7:0]     product;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE) && !pend_vld_reg;
    assign out_free = !out_vld_reg || m_ready;

    assign vco     = {2'b00, freq_m_reg[5:0]} + VCO_OFFSET;
    // post divider 8 >> D is 1 << (3 - D)
    assign divisor = DIVISOR_W'({3'b000, freq_n_reg[4:0]} << (2'd3 - freq_m_reg[7:6]));
    assign product = ref_clk_reg * vco;

    assign div_req.start    = (state_reg == ST_MUL);
    assign div_req.dividend = product[CLK_W-1:0];
    assign div_req.divisor  = divisor;

    rpp_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next     = state_reg;
        pal_ptr_next   = pal_ptr_reg;
        comp_cnt_next  = comp_cnt_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        idx_low_next   = idx_low_reg;
        idx_high_next  = idx_high_reg;
        pll_ctl_next   = pll_ctl_reg;
        freq_m_next    = freq_m_reg;
        freq_n_next    = freq_n_reg;
        pend_vld_next  = pend_vld_reg;
        pend_res_next  = pend_res_reg;

        // drain the holding register into the output register
        if (pend_vld_reg && out_free) begin
            pend_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    pend_res_next = '0;
                    pend_res_next.error_code = ERR_NONE;
                    pend_vld_next = 1'b1;
                    unique case (s_action)
                        ACT_PAL_ADDR: pal_ptr_next = s_data_byte;
                        ACT_PAL_DATA: begin
                            if (comp_cnt_reg == 2'd0) begin
                                red_next      = s_data_byte;
                                comp_cnt_next = 2'd1;
                            end else if (comp_cnt_reg == 2'd1) begin
                                green_next    = s_data_byte;
                                comp_cnt_next = 2'd2;
                            end else begin
                                pend_res_next.palette_write = 1'b1;
                                pend_res_next.palette_index = pal_ptr_reg;
                                pend_res_next.palette_red   = red_reg;
                                pend_res_next.palette_green = green_reg;
                                pend_res_next.palette_blue  = s_data_byte;
                                pal_ptr_next  = pal_ptr_reg + 8'd1;
                                comp_cnt_next = 2'd0;
                            end
                        end
                        ACT_PIX_MASK: ;
                        ACT_IDX_LOW:  idx_low_next  = s_data_byte;
                        ACT_IDX_HIGH: idx_high_next = s_data_byte;
                        ACT_IDX_DATA: begin
                            unique case (idx_low_reg)
                                IDX_PLL_CTL: pll_ctl_next = s_data_byte;
                                IDX_FREQ_M:  freq_m_next  = s_data_byte;
                                IDX_FREQ_N:  freq_n_next  = s_data_byte;
                                IDX_CLK_CNTL: begin
                                    if (s_data_byte[0]) begin
                                        if (pll_ctl_reg[1:0] != PLL_SRC_OK) begin
                                            pend_res_next.error_code = ERR_PLL_SRC;
                                        end else if (divisor == '0) begin
                                            pend_res_next.error_code = ERR_ZERO_DIV;
                                        end else begin
                                            // hold the result until the divider finishes
                                            pend_vld_next = 1'b0;
                                            state_next    = ST_MUL;
                                        end
                                    end
                                end
                                IDX_PIX_FORMAT: begin
                                    if (s_data_byte == PIX_FMT_8BPP) begin
                                        pend_res_next.depth_set = 1'b1;
                                    end else begin
                                        pend_res_next.error_code = ERR_PIX_FMT;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        default: pend_res_next.error_code = ERR_UNIMPL;
                    endcase
                end
            end
            ST_MUL: state_next = ST_DIV;
            ST_DIV: begin
                if (div_rsp.done) begin
                    pend_res_next                = '0;
                    pend_res_next.error_code     = ERR_NONE;
                    pend_res_next.clock_update   = 1'b1;
                    pend_res_next.pixel_clock_hz = div_rsp.quotient;
                    pend_vld_next                = 1'b1;
                    state_next                   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        pend_res_reg <= pend_res_next;
        if (pend_vld_reg && out_free) begin
            out_res_reg <= pend_res_reg;
        end
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ref_clk_reg  <= REF_CLK_RESET;
            pal_ptr_reg  <= '0;
            comp_cnt_reg <= '0;
            red_reg      <= '0;
            green_reg    <= '0;
            idx_low_reg  <= '0;
            idx_high_reg <= '0;
            pll_ctl_reg  <= '0;
            freq_m_reg   <= '0;
            freq_n_reg   <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            if (cfg_wr_en) begin
                ref_clk_reg <= cfg_wr_data;
            end
            pal_ptr_reg  <= pal_ptr_next;
            comp_cnt_reg <= comp_cnt_next;
            red_reg      <= red_next;
            green_reg    <= green_next;
            idx_low_reg  <= idx_low_next;
            idx_high_reg <= idx_high_next;
            pll_ctl_reg  <= pll_ctl_next;
            freq_m_reg   <= freq_m_next;
            freq_n_reg   <= freq_n_next;
            pend_vld_reg <= pend_vld_next;
            if (pend_vld_reg && out_free) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = out_vld_reg;
    assign m_palette_write  = out_res_reg.palette_write;
    assign m_palette_index  = out_res_reg.palette_index;
    assign m_palette_red    = out_res_reg.palette_red;
    assign m_palette_green  = out_res_reg.palette_green;
    assign m_palette_blue   = out_res_reg.palette_blue;
    assign m_clock_update   = out_res_reg.clock_update;
    assign m_pixel_clock_hz = out_res_reg.pixel_clock_hz;
    assign m_depth_set      = out_res_reg.depth_set;
    assign m_error_code     = out_res_reg.error_code;

    a_no_accept_while_div : assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.busy |-> !s_ready)
        else $error("input taken while divider busy");

    a_done_in_div : assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide state");

    a_divisor_nonzero : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (divisor != '0))
        else $error("divide started with zero divisor");

    a_pend_only_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        pend_vld_reg |-> (state_reg == ST_IDLE))
        else $error("held result while a calculation runs");

    a_clock_result : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && div_rsp.done) |=> (pend_vld_reg && pend_res_reg.clock_update))
        else $error("divider result not captured");

endmodule
